### hdl/kpt_pkg.sv
// Package for the keyed periodic timer bank: sizes, command and result codes,
// queue item and table entry types. No dependencies; every other file imports it.

package kpt_pkg;

  // table size, reporting limit and queue depth
  localparam int MAX_TIMERS   = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int Q_DEPTH      = 2;

  // field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 16;
  localparam int PERIOD_W = 32;
  localparam int KIND_W   = 3;

  // derived widths
  localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int FILL_W = $clog2(MAX_TIMERS + 1);
  localparam int NCNT_W = $clog2(RESULT_LIMIT + 1);
  localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSTALL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNINSTALL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_INSTALLED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DUPLICATE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd5;

  // command waiting between front and engine
  typedef struct packed {
    logic [CMD_W-1:0]    op;
    logic [KEY_W-1:0]    timer_id;
    logic [PERIOD_W-1:0] period;
    logic                has_action;
  } cmd_item_t;

  // one timer slot; slots are kept sorted by key
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] count;
    logic                action;
  } entry_t;

endpackage

### hdl/kpt_if.sv
// Valid/ready channel interfaces for the timer bank's command input and result output.
// Depends on kpt_pkg for field widths.

interface kpt_in_if;
  import kpt_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_W-1:0]    timer_id;
  logic [PERIOD_W-1:0] period;
  logic                has_action;

  modport source (output valid, output cmd, output timer_id, output period,
                  output has_action, input ready);
  modport sink   (input valid, input cmd, input timer_id, input period,
                  input has_action, output ready);
endinterface

interface kpt_out_if;
  import kpt_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  fired_id;
  logic              last;

  modport source (output valid, output kind, output fired_id, output last, input ready);
  modport sink   (input valid, input kind, input fired_id, input last, output ready);
endinterface

### hdl/kpt_front.sv
// Front end: accepts command items, drops the unused code and queues the rest
// for the engine. Depends on kpt_pkg and kpt_in_if.

module kpt_front import kpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  kpt_in_if.sink     in_ch,
  output logic       q_valid,
  output cmd_item_t  q_item,
  input  logic       q_pop
);

  cmd_item_t         slot_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              take;
  logic              push;
  logic              pop;
  cmd_item_t         item_in;

  // accept while the queue has room
  assign in_ch.ready = (cnt_r != QCNT_W'(Q_DEPTH));
  assign take        = in_ch.valid && in_ch.ready;

  // classify: the unused code is accepted and dropped
  assign push = take && (in_ch.cmd != CMD_UNUSED);
  assign pop  = q_pop && q_valid;

  assign item_in.op         = in_ch.cmd;
  assign item_in.timer_id   = in_ch.timer_id;
  assign item_in.period     = in_ch.period;
  assign item_in.has_action = in_ch.has_action;

  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  // advance pointers, wrapping at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store queued items
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

### hdl/kpt_engine.sv
// Back end: executes queued commands on the key-sorted timer table and drives
// the registered result channel. Depends on kpt_pkg and kpt_out_if.

module kpt_engine import kpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_item_t  q_item,
  output logic       q_pop,
  kpt_out_if.source  out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // table and control state
  entry_t            entry_r [MAX_TIMERS];
  entry_t            entry_nxt [MAX_TIMERS];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [NCNT_W-1:0] nfire_r, nfire_nxt;
  logic              held_v_r, held_v_nxt;
  logic [KEY_W-1:0]  held_key_r, held_key_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [KEY_W-1:0]  out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;
  logic              can_push;

  // key search over all slots
  logic [MAX_TIMERS-1:0] slot_used;
  logic [MAX_TIMERS-1:0] lt;
  logic [MAX_TIMERS-1:0] hit;
  logic [MAX_TIMERS-1:0] hit_pre;
  entry_t                ins_entry [MAX_TIMERS];
  entry_t                del_entry [MAX_TIMERS];
  entry_t                new_entry;
  logic                  dup;
  logic                  full;

  // scan step
  entry_t              cur;
  logic                in_range;
  logic [PERIOD_W-1:0] cnt_inc;
  logic                expire;
  logic                fire_take;

  assign can_push = !out_valid_r || out_ch.ready;

  assign new_entry.key    = q_item.timer_id;
  assign new_entry.period = q_item.period;
  assign new_entry.count  = '0;
  assign new_entry.action = q_item.has_action;

  // compare every slot against the command key; build shifted tables
  for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_slot
    assign slot_used[i] = (FILL_W'(i) < fill_r);
    assign lt[i]        = slot_used[i] && (entry_r[i].key < q_item.timer_id);
    assign hit[i]       = slot_used[i] && (entry_r[i].key == q_item.timer_id);

    if (i == 0) begin : g_first
      assign hit_pre[i]   = hit[i];
      assign ins_entry[i] = lt[i] ? entry_r[i] : new_entry;
    end else begin : g_rest
      assign hit_pre[i]   = hit_pre[i-1] | hit[i];
      assign ins_entry[i] = lt[i]   ? entry_r[i] :
                            lt[i-1] ? new_entry  : entry_r[i-1];
    end

    if (i == MAX_TIMERS - 1) begin : g_top
      assign del_entry[i] = entry_r[i];
    end else begin : g_below
      assign del_entry[i] = hit_pre[i] ? entry_r[i+1] : entry_r[i];
    end
  end

  assign dup  = |hit;
  assign full = (fill_r == FILL_W'(MAX_TIMERS));

  // one slot of the tick scan
  assign cur       = entry_r[idx_r];
  assign in_range  = (FILL_W'(idx_r) < fill_r);
  assign cnt_inc   = (cur.count < cur.period) ? cur.count + 1'b1 : cur.count;
  assign expire    = (cnt_inc >= cur.period);
  assign fire_take = in_range && expire && cur.action &&
                     (nfire_r < NCNT_W'(RESULT_LIMIT));

  always_comb begin
    entry_nxt     = entry_r;
    fill_nxt      = fill_r;
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    nfire_nxt     = nfire_r;
    held_v_nxt    = held_v_r;
    held_key_nxt  = held_key_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            CMD_TICK: begin
              q_pop      = 1'b1;
              state_nxt  = ST_SCAN;
              idx_nxt    = '0;
              nfire_nxt  = '0;
              held_v_nxt = 1'b0;
            end
            CMD_INSTALL: begin
              if (can_push) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_id_nxt    = q_item.timer_id;
                out_last_nxt  = 1'b1;
                if (dup) begin
                  out_kind_nxt = KIND_DUPLICATE;
                end else if (full) begin
                  out_kind_nxt = KIND_FULL;
                end else begin
                  out_kind_nxt = KIND_INSTALLED;
                  entry_nxt    = ins_entry;
                  fill_nxt     = fill_r + 1'b1;
                end
              end
            end
            CMD_UNINSTALL: begin
              if (can_push) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_id_nxt    = q_item.timer_id;
                out_last_nxt  = 1'b1;
                if (dup) begin
                  out_kind_nxt = KIND_REMOVED;
                  entry_nxt    = del_entry;
                  fill_nxt     = fill_r - 1'b1;
                end else begin
                  out_kind_nxt = KIND_NOT_FOUND;
                end
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // stall only when a held fire must go out and the result register is busy
        if (!(fire_take && held_v_r && !can_push)) begin
          if (in_range) begin
            entry_nxt[idx_r].count = expire ? '0 : cnt_inc;
          end
          if (fire_take) begin
            if (held_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_FIRED;
              out_id_nxt    = held_key_r;
              out_last_nxt  = 1'b0;
            end
            held_v_nxt   = 1'b1;
            held_key_nxt = cur.key;
            nfire_nxt    = nfire_r + 1'b1;
          end
          if (idx_r == IDX_W'(MAX_TIMERS - 1)) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        // emit the final fire marked last
        if (!held_v_r) begin
          state_nxt = ST_IDLE;
        end else if (can_push) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIRED;
          out_id_nxt    = held_key_r;
          out_last_nxt  = 1'b1;
          held_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      nfire_r     <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      nfire_r     <= nfire_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    entry_r    <= entry_nxt;
    held_key_r <= held_key_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.fired_id = out_id_r;
  assign out_ch.last     = out_last_r;

endmodule

### hdl/keyed_periodic_timer_bank_top.sv
// Top level of the keyed periodic timer bank: command front end, queue and engine.
// Depends on kpt_pkg, kpt_if, kpt_front and kpt_engine.
//
//   channel  dir  handshake            payload
//   in_ch    in   in_ch.valid/ready    cmd, timer_id, period, has_action
//   out_ch   out  out_ch.valid/ready   kind, fired_id, last
//
// For install and uninstall, the key compare over all slots and the sorted-table shift
// happen together in the same cycle.
// A tick is decoded, then the single count-update unit walks the key-sorted table one
// slot per cycle unless a held fire stalls it, then the final fire goes out.
// A two-item queue keeps accepting commands while the engine scans, until it is full.
// Reset is synchronous, active low, and empties the table and the queue at once.
// The engine holds an install, an uninstall, a scan step at a second or later fire,
// or the final fire while the result register is full and not being taken.

module keyed_periodic_timer_bank_top import kpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  kpt_in_if.sink     in_ch,
  kpt_out_if.source  out_ch
);

  logic      q_valid;
  logic      q_pop;
  cmd_item_t q_item;

  kpt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  kpt_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### tb/tb_keyed_periodic_timer_bank_top.sv
// Testbench for the keyed periodic timer bank: directed command table, then random traffic,
// checked against an in-bench model of the timer table. Depends on kpt_pkg, kpt_if, the top.
`timescale 1ns / 1ps

module tb_keyed_periodic_timer_bank_top;
  import kpt_pkg::*;

  localparam int KEY_POOL     = 24;
  localparam int FILL_ITEMS   = 30;
  localparam int MIXED_ITEMS  = 30;
  localparam int STEADY_ITEMS = 17;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 2 * (MAX_TIMERS + 2);
  localparam int DIRECTED_ROWS = 23;

  // one result item as seen on the output channel
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  fired_id;
    logic              last;
  } timer_result_t;

  // directed row: command, plus a hand-written result where it is obvious
  typedef struct packed {
    logic [CMD_W-1:0]    op;
    logic [KEY_W-1:0]    timer_id;
    logic [PERIOD_W-1:0] period;
    logic                has_action;
    logic                typed;
    logic                has_res;
    logic [KIND_W-1:0]   kind;
  } directed_row_t;

  logic clk;
  logic rst_n;
  kpt_in_if  in_ch ();
  kpt_out_if out_ch ();

  keyed_periodic_timer_bank_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // model of the timer table
  logic                slot_used   [MAX_TIMERS];
  logic [KEY_W-1:0]    slot_key    [MAX_TIMERS];
  logic [PERIOD_W-1:0] slot_period [MAX_TIMERS];
  logic [PERIOD_W-1:0] slot_count  [MAX_TIMERS];
  logic                slot_action [MAX_TIMERS];

  timer_result_t step_out[$];
  timer_result_t timer_results_due[$];

  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int  fill_next;
  int  error_cnt;
  int  results_seen;
  int  kind_seen [6];
  int  cmds_sent [4];
  bit  steady_flow;
  int  idle_cycles;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_TICK,      16'h0000, 32'd0,          1'b0, 1'b1, 1'b0, KIND_FIRED},
    '{CMD_UNINSTALL, 16'h0000, 32'd0,          1'b0, 1'b1, 1'b1, KIND_NOT_FOUND},
    '{CMD_INSTALL,   16'h0000, 32'd0,          1'b1, 1'b1, 1'b1, KIND_INSTALLED},
    '{CMD_INSTALL,   16'h0000, 32'd5,          1'b0, 1'b1, 1'b1, KIND_DUPLICATE},
    '{CMD_INSTALL,   16'hFFFF, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1, KIND_INSTALLED},
    '{CMD_INSTALL,   16'h8000, 32'd1,          1'b1, 1'b1, 1'b1, KIND_INSTALLED},
    '{CMD_INSTALL,   16'h1234, 32'd2,          1'b0, 1'b1, 1'b1, KIND_INSTALLED},
    '{CMD_TICK,      16'h5555, 32'hAAAA_AAAA,  1'b1, 1'b0, 1'b0, KIND_FIRED},
    '{CMD_TICK,      16'h0000, 32'd0,          1'b0, 1'b0, 1'b0, KIND_FIRED},
    '{CMD_UNUSED,    16'hFFFF, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, KIND_FIRED},
    '{CMD_UNINSTALL, 16'hFFFF, 32'hA5A5_A5A5,  1'b1, 1'b1, 1'b1, KIND_REMOVED},
    '{CMD_UNINSTALL, 16'hFFFF, 32'd0,          1'b0, 1'b1, 1'b1, KIND_NOT_FOUND},
    '{CMD_INSTALL,   16'h00FF, 32'd3,          1'b1, 1'b1, 1'b1, KIND_INSTALLED},
    '{CMD_TICK,      16'h0000, 32'd0,          1'b0, 1'b0, 1'b0, KIND_FIRED},
    '{CMD_TICK,      16'h0000, 32'd0,          1'b0, 1'b0, 1'b0, KIND_FIRED},
    '{CMD_TICK,      16'h0000, 32'd0,          1'b0, 1'b0, 1'b0, KIND_FIRED},
    '{CMD_UNINSTALL, 16'h8000, 32'd0,          1'b0, 1'b1, 1'b1, KIND_REMOVED},
    '{CMD_INSTALL,   16'h7FFF, 32'h8000_0000,  1'b1, 1'b1, 1'b1, KIND_INSTALLED},
    '{CMD_TICK,      16'h0000, 32'd0,          1'b0, 1'b0, 1'b0, KIND_FIRED},
    '{CMD_UNINSTALL, 16'h0000, 32'd0,          1'b0, 1'b1, 1'b1, KIND_REMOVED},
    '{CMD_UNINSTALL, 16'h1234, 32'd0,          1'b0, 1'b1, 1'b1, KIND_REMOVED},
    '{CMD_UNINSTALL, 16'h00FF, 32'd0,          1'b0, 1'b1, 1'b1, KIND_REMOVED},
    '{CMD_UNINSTALL, 16'h7FFF, 32'd0,          1'b0, 1'b1, 1'b1, KIND_REMOVED}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic timer_result_t result_of(input logic [KIND_W-1:0] kind,
                                              input logic [KEY_W-1:0] id,
                                              input logic last);
    timer_result_t r;
    r.kind     = kind;
    r.fired_id = id;
    r.last     = last;
    return r;
  endfunction

  // apply one command to the table model; results land in step_out
  function automatic void advance_timer_table(input cmd_item_t c);
    int slot;
    int free_slot;
    int n;
    int j;
    logic [KEY_W-1:0] fired [MAX_TIMERS];
    step_out.delete();
    slot = -1;
    free_slot = -1;
    n = 0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      if (slot < 0 && slot_used[i] && slot_key[i] == c.timer_id) slot = i;
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    end
    case (c.op)
      CMD_INSTALL: begin
        if (slot >= 0) begin
          step_out.push_back(result_of(KIND_DUPLICATE, c.timer_id, 1'b1));
        end else if (free_slot < 0) begin
          step_out.push_back(result_of(KIND_FULL, c.timer_id, 1'b1));
        end else begin
          slot_used[free_slot]   = 1'b1;
          slot_key[free_slot]    = c.timer_id;
          slot_period[free_slot] = c.period;
          slot_count[free_slot]  = '0;
          slot_action[free_slot] = c.has_action;
          step_out.push_back(result_of(KIND_INSTALLED, c.timer_id, 1'b1));
        end
      end
      CMD_UNINSTALL: begin
        if (slot < 0) begin
          step_out.push_back(result_of(KIND_NOT_FOUND, c.timer_id, 1'b1));
        end else begin
          slot_used[slot] = 1'b0;
          step_out.push_back(result_of(KIND_REMOVED, c.timer_id, 1'b1));
        end
      end
      CMD_TICK: begin
        // advance every live timer, gather the expiring keys of timers with an action in ascending order
        for (int i = 0; i < MAX_TIMERS; i++) begin
          if (slot_used[i]) begin
            if (slot_count[i] < slot_period[i]) slot_count[i] = slot_count[i] + 1;
            if (slot_count[i] >= slot_period[i]) begin
              slot_count[i] = '0;
              if (slot_action[i]) begin
                j = n;
                while (j > 0 && fired[j-1] > slot_key[i]) begin
                  fired[j] = fired[j-1];
                  j--;
                end
                fired[j] = slot_key[i];
                n++;
              end
            end
          end
        end
        if (n > RESULT_LIMIT) n = RESULT_LIMIT;
        for (int k = 0; k < n; k++)
          step_out.push_back(result_of(KIND_FIRED, fired[k], (k == n - 1)));
      end
      default: ;
    endcase
  endfunction

  function automatic logic [PERIOD_W-1:0] random_period();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return PERIOD_W'($urandom_range(0, 1));
    if (pick < 8) return PERIOD_W'($urandom_range(2, 6));
    return PERIOD_W'($urandom);
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    if ($urandom_range(0, 6) == 0) return KEY_W'($urandom_range(0, 65535));
    return key_pool[$urandom_range(0, KEY_POOL - 1)];
  endfunction

  // fill phase: mostly fresh keys that fire every tick; later: mixed traffic
  function automatic cmd_item_t random_command(input bit filling);
    cmd_item_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.timer_id   = random_key();
    c.period     = random_period();
    c.has_action = ($urandom_range(0, 3) != 0);
    if (filling) begin
      if (pick < 75) begin
        c.op = CMD_INSTALL;
        if ($urandom_range(0, 99) < 85) begin
          c.timer_id   = key_pool[fill_next % KEY_POOL];
          c.period     = PERIOD_W'($urandom_range(0, 1));
          c.has_action = 1'b1;
          fill_next++;
        end
      end else if (pick < 95) begin
        c.op = CMD_TICK;
      end else begin
        c.op = CMD_UNINSTALL;
      end
    end else begin
      if (pick < 35)      c.op = CMD_TICK;
      else if (pick < 65) c.op = CMD_INSTALL;
      else if (pick < 95) c.op = CMD_UNINSTALL;
      else                c.op = CMD_UNUSED;
    end
    return c;
  endfunction

  // present one item, hold it until accepted
  task automatic drive_command(input cmd_item_t c);
    int gap;
    gap = 0;
    @(negedge clk);
    if (!steady_flow && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c.op;
    in_ch.timer_id   <= c.timer_id;
    in_ch.period     <= c.period;
    in_ch.has_action <= c.has_action;
    do @(posedge clk); while (!in_ch.ready);
    cmds_sent[c.op]++;
  endtask

  // stimulus
  initial begin : stimulus
    cmd_item_t c;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TICK;
    in_ch.timer_id = '0;
    in_ch.period = '0;
    in_ch.has_action = 1'b0;
    steady_flow = 1'b0;
    fill_next = 0;
    error_cnt = 0;
    results_seen = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    foreach (cmds_sent[k]) cmds_sent[k] = 0;
    foreach (slot_used[i]) begin
      slot_used[i]   = 1'b0;
      slot_key[i]    = '0;
      slot_period[i] = '0;
      slot_count[i]  = '0;
      slot_action[i] = 1'b0;
    end
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'h8000;
    key_pool[3] = 16'h0001;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom_range(0, 65535));

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[r]) begin
      c.op         = directed_rows[r].op;
      c.timer_id   = directed_rows[r].timer_id;
      c.period     = directed_rows[r].period;
      c.has_action = directed_rows[r].has_action;
      drive_command(c);
      advance_timer_table(c);
      if (directed_rows[r].typed) begin
        if (directed_rows[r].has_res)
          timer_results_due.push_back(result_of(directed_rows[r].kind, c.timer_id, 1'b1));
      end else begin
        foreach (step_out[k]) timer_results_due.push_back(step_out[k]);
      end
    end

    // random traffic: fill, mixed, then mixed with no idling
    for (int n = 0; n < FILL_ITEMS + MIXED_ITEMS + STEADY_ITEMS; n++) begin
      if (n == FILL_ITEMS + MIXED_ITEMS) steady_flow = 1'b1;
      c = random_command(n < FILL_ITEMS);
      drive_command(c);
      advance_timer_table(c);
      foreach (step_out[k]) timer_results_due.push_back(step_out[k]);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain, then keep watching for stray results before the summary
    while (timer_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d ticks, %0d installs, %0d uninstalls, %0d unused commands.",
             cmds_sent[CMD_TICK], cmds_sent[CMD_INSTALL], cmds_sent[CMD_UNINSTALL],
             cmds_sent[CMD_UNUSED]);
    $display("Checked %0d results: %0d fires, %0d table-full, %0d duplicates, %0d not found.",
             results_seen, kind_seen[KIND_FIRED], kind_seen[KIND_FULL],
             kind_seen[KIND_DUPLICATE], kind_seen[KIND_NOT_FOUND]);
    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result sink: random stall bursts, always ready in the last part
  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady_flow) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest one due
  always @(posedge clk) begin
    timer_result_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.kind <= KIND_FIRED) kind_seen[out_ch.kind]++;
      if (timer_results_due.size() == 0) begin
        $error("unexpected result: kind %0d fired_id 0x%04h last %0d",
               out_ch.kind, out_ch.fired_id, out_ch.last);
        error_cnt++;
      end else begin
        due = timer_results_due.pop_front();
        if (out_ch.kind !== due.kind) begin
          $error("kind mismatch: expected %0d, got %0d", due.kind, out_ch.kind);
          error_cnt++;
        end
        if (out_ch.fired_id !== due.fired_id) begin
          $error("fired_id mismatch: expected 0x%04h, got 0x%04h", due.fired_id,
                 out_ch.fired_id);
          error_cnt++;
        end
        if (out_ch.last !== due.last) begin
          $error("last mismatch: expected %0d, got %0d", due.last, out_ch.last);
          error_cnt++;
        end
      end
    end
  end

  // watchdog: end the run when no item moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timed out with %0d results still due.", timer_results_due.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### keyed_periodic_timer_bank_top.f
hdl/kpt_pkg.sv
hdl/kpt_if.sv
hdl/kpt_front.sv
hdl/kpt_engine.sv
hdl/keyed_periodic_timer_bank_top.sv
tb/tb_keyed_periodic_timer_bank_top.sv
